[hdl/cpr_pkg.sv]
// Shared types and constants of the command packet reassembler.
package cpr_pkg;

    // Control codes carried in the first byte of a packet.
    localparam logic [7:0] CODE_START      = 8'h80;
    localparam logic [7:0] CODE_START_STRM = 8'hC0;
    localparam logic [7:0] CODE_CONT       = 8'h88;
    localparam logic [7:0] CODE_CONT_STRM  = 8'hC8;

    localparam int START_HDR_SIZE = 5;
    localparam int CONT_HDR_SIZE  = 1;

    localparam int PACKET_SIZE_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] CMD_BUF_RESET = 16'd512;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_ABORT    = 2'd2
    } t_kind;

    // Work for the back end: an optional buffer write followed by an
    // optional event (dispatch or abort).
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [7:0]  wr_data;
        logic        ev_en;
        t_kind       ev_kind;
        logic [31:0] ev_chunk;
        logic [31:0] ev_total;
        logic        ev_first;
        logic        ev_strm;
    } t_entry;

    // One result on the output channel.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic [31:0] chunk_bytes;
        logic [31:0] total_bytes;
        logic        first_chunk;
        logic        streamed;
        logic        last;
    } t_result;

endpackage

[hdl/cpr_front.sv]
// Front end: accepts packet bytes, tracks command state, classifies each byte.
module cpr_front #(
    parameter int PACKET_SIZE = cpr_pkg::PACKET_SIZE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_in_byte,
    input  logic            i_packet_start,
    input  logic            i_response_busy,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    output logic            o_push,
    output cpr_pkg::t_entry o_entry
);
    localparam int IDX_W = $clog2(PACKET_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(PACKET_SIZE - 1);
    localparam logic [IDX_W-1:0] ROOM_START =
        IDX_W'(PACKET_SIZE - cpr_pkg::START_HDR_SIZE);
    localparam logic [IDX_W-1:0] ROOM_CONT  =
        IDX_W'(PACKET_SIZE - cpr_pkg::CONT_HDR_SIZE);
    localparam logic [IDX_W-1:0] HDR_START  = IDX_W'(cpr_pkg::START_HDR_SIZE);
    localparam logic [IDX_W-1:0] HDR_CONT   = IDX_W'(cpr_pkg::CONT_HDR_SIZE);
    localparam logic [IDX_W-1:0] HDR_LAST   = IDX_W'(cpr_pkg::START_HDR_SIZE - 1);

    logic [15:0]      r_buf_bytes,   n_buf_bytes;
    logic [IDX_W-1:0] r_byte_index,  n_byte_index;
    logic [7:0]       r_control_code, n_control_code;
    logic [23:0]      r_hdr_len,     n_hdr_len;
    logic [31:0]      r_total,       n_total;
    logic [31:0]      r_bytes_left,  n_bytes_left;
    logic [15:0]      r_write_offset, n_write_offset;
    logic             r_expect_cont, n_expect_cont;
    logic             r_streaming,   n_streaming;
    logic             r_pkt_acc,     n_pkt_acc;
    logic [IDX_W-1:0] r_chunk_count, n_chunk_count;
    logic             r_chunk_first, n_chunk_first;

    logic             dec_go;
    logic [IDX_W-1:0] dec_room;
    logic [31:0]      dec_bl;
    logic [31:0]      dec_tl;
    logic [15:0]      dec_wo;
    logic [IDX_W-1:0] dec_c;
    logic [31:0]      dec_bl_new;
    logic             dec_over;
    logic             do_abort;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] hdr;
    logic [IDX_W-1:0] off;
    logic [15:0]      base;
    logic             is_start;
    logic [31:0]      full_len;

    always_comb begin
        n_buf_bytes    = i_cfg_we ? i_cfg_data : r_buf_bytes;
        n_byte_index   = r_byte_index;
        n_control_code = r_control_code;
        n_hdr_len      = r_hdr_len;
        n_total        = r_total;
        n_bytes_left   = r_bytes_left;
        n_write_offset = r_write_offset;
        n_expect_cont  = r_expect_cont;
        n_streaming    = r_streaming;
        n_pkt_acc      = r_pkt_acc;
        n_chunk_count  = r_chunk_count;
        n_chunk_first  = r_chunk_first;
        o_entry        = '0;
        dec_go         = 1'b0;
        dec_room       = ROOM_CONT;
        dec_bl         = r_bytes_left;
        dec_tl         = r_total;
        dec_wo         = r_write_offset;
        do_abort       = 1'b0;
        is_start       = (r_control_code == cpr_pkg::CODE_START) ||
                         (r_control_code == cpr_pkg::CODE_START_STRM);
        idx            = r_byte_index + 1'b1;
        hdr            = is_start ? HDR_START : HDR_CONT;
        off            = idx - hdr;
        full_len       = {i_in_byte, r_hdr_len};
        base           = (!r_streaming && r_bytes_left != 32'd0) ?
                         r_write_offset - 16'(r_chunk_count) : r_write_offset;

        if (i_accept) begin
            if (i_packet_start) begin
                n_byte_index   = '0;
                n_control_code = i_in_byte;
                n_chunk_count  = '0;
                n_pkt_acc      = !i_response_busy;
                if (!i_response_busy) begin
                    if (i_in_byte == cpr_pkg::CODE_CONT ||
                        i_in_byte == cpr_pkg::CODE_CONT_STRM) begin
                        if (!r_expect_cont) begin
                            do_abort = 1'b1;
                        end else begin
                            dec_go = 1'b1;
                        end
                    end else if (i_in_byte != cpr_pkg::CODE_START &&
                                 i_in_byte != cpr_pkg::CODE_START_STRM) begin
                        do_abort = 1'b1;
                    end
                end
            end else if (r_pkt_acc && r_byte_index < LAST_IDX) begin
                n_byte_index = idx;
                if (is_start && idx < HDR_START) begin
                    // Collect the little-endian length; decide at its top byte.
                    case (idx)
                        IDX_W'(1): n_hdr_len[7:0]   = i_in_byte;
                        IDX_W'(2): n_hdr_len[15:8]  = i_in_byte;
                        IDX_W'(3): n_hdr_len[23:16] = i_in_byte;
                        default: ;
                    endcase
                    if (idx == HDR_LAST) begin
                        n_total        = full_len;
                        n_bytes_left   = full_len;
                        n_write_offset = '0;
                        n_expect_cont  = 1'b1;
                        n_streaming    = (r_control_code == cpr_pkg::CODE_START_STRM);
                        dec_go         = 1'b1;
                        dec_room       = ROOM_START;
                        dec_bl         = full_len;
                        dec_tl         = full_len;
                        dec_wo         = '0;
                    end
                end else if (idx >= hdr && off < r_chunk_count) begin
                    o_entry.wr_en   = 1'b1;
                    o_entry.wr_addr = base + 16'(off);
                    o_entry.wr_data = i_in_byte;
                end

                if (idx == LAST_IDX) begin
                    if (r_streaming) begin
                        o_entry.ev_en    = 1'b1;
                        o_entry.ev_kind  = cpr_pkg::KIND_DISPATCH;
                        o_entry.ev_chunk = 32'(r_chunk_count);
                        o_entry.ev_total = r_total;
                        o_entry.ev_first = r_chunk_first;
                        o_entry.ev_strm  = 1'b1;
                    end else if (r_bytes_left == 32'd0) begin
                        o_entry.ev_en    = 1'b1;
                        o_entry.ev_kind  = cpr_pkg::KIND_DISPATCH;
                        o_entry.ev_chunk = r_total;
                        o_entry.ev_total = r_total;
                        o_entry.ev_first = r_chunk_first;
                    end
                    n_pkt_acc = 1'b0;
                end
            end
        end

        // Chunk decision: size the chunk, check capacity, advance counters.
        dec_c      = (dec_bl < 32'(dec_room)) ? dec_bl[IDX_W-1:0] : dec_room;
        dec_over   = ({1'b0, dec_wo} + 17'(dec_c)) > {1'b0, r_buf_bytes};
        dec_bl_new = dec_bl - 32'(dec_c);
        if (dec_go) begin
            if (dec_over) begin
                do_abort = 1'b1;
            end else begin
                n_chunk_first = (dec_bl == dec_tl);
                n_bytes_left  = dec_bl_new;
                n_chunk_count = dec_c;
                if (!n_streaming && dec_bl_new != 32'd0) begin
                    n_write_offset = dec_wo + 16'(dec_c);
                end
            end
        end

        if (do_abort) begin
            n_total        = '0;
            n_bytes_left   = '0;
            n_write_offset = '0;
            n_expect_cont  = 1'b0;
            n_chunk_count  = '0;
            n_pkt_acc      = 1'b0;
            o_entry        = '0;
            o_entry.ev_en  = 1'b1;
            o_entry.ev_kind = cpr_pkg::KIND_ABORT;
        end

        o_push = o_entry.wr_en || o_entry.ev_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes    <= cpr_pkg::CMD_BUF_RESET;
            r_byte_index   <= '0;
            r_control_code <= '0;
            r_total        <= '0;
            r_bytes_left   <= '0;
            r_write_offset <= '0;
            r_expect_cont  <= 1'b0;
            r_streaming    <= 1'b0;
            r_pkt_acc      <= 1'b0;
            r_chunk_count  <= '0;
            r_chunk_first  <= 1'b0;
        end else begin
            r_buf_bytes    <= n_buf_bytes;
            r_byte_index   <= n_byte_index;
            r_control_code <= n_control_code;
            r_total        <= n_total;
            r_bytes_left   <= n_bytes_left;
            r_write_offset <= n_write_offset;
            r_expect_cont  <= n_expect_cont;
            r_streaming    <= n_streaming;
            r_pkt_acc      <= n_pkt_acc;
            r_chunk_count  <= n_chunk_count;
            r_chunk_first  <= n_chunk_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_len <= n_hdr_len;
    end

endmodule

[hdl/cpr_queue.sv]
// Short work queue between the front end and the back end.
module cpr_queue #(
    parameter int DEPTH = cpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpr_pkg::t_entry i_entry,
    input  logic            i_pop,
    output cpr_pkg::t_entry o_head,
    output logic            o_not_empty,
    output logic            o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cpr_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && o_not_empty;
        n_wr_ptr = do_push ? ((r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? ((r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_full      = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[hdl/cpr_back.sv]
// Back end: expands queued work into results and holds the output register.
module cpr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cpr_pkg::t_entry  i_head,
    input  logic             i_head_valid,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output cpr_pkg::t_result o_result
);
    logic             r_valid,  n_valid;
    logic             r_phase,  n_phase;
    cpr_pkg::t_result r_result, n_result;
    logic             load;

    always_comb begin
        load     = !r_valid || !i_out_stall;
        n_valid  = r_valid;
        n_phase  = r_phase;
        n_result = r_result;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = i_head_valid;
            if (i_head_valid) begin
                n_result = '0;
                if (i_head.wr_en && !r_phase) begin
                    n_result.kind       = cpr_pkg::KIND_WRITE;
                    n_result.write_addr = i_head.wr_addr;
                    n_result.write_data = i_head.wr_data;
                    n_result.last       = !i_head.ev_en;
                    // Hold the entry when its event still follows.
                    n_phase = i_head.ev_en;
                    o_pop   = !i_head.ev_en;
                end else begin
                    n_result.kind        = i_head.ev_kind;
                    n_result.chunk_bytes = i_head.ev_chunk;
                    n_result.total_bytes = i_head.ev_total;
                    n_result.first_chunk = i_head.ev_first;
                    n_result.streamed    = i_head.ev_strm;
                    n_result.last        = 1'b1;
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

[hdl/command_packet_reassembler.sv]
// Top level of the command packet reassembler: front end, work queue, back end.
// Throughput: one byte per cycle; the back end sends one result per cycle unless
//   the output stalls, so the queue absorbs the second result of a byte with a
//   write and a dispatch. The input stalls only while the work queue is full,
//   which takes output stalls.
// Reset (synchronous, active low): command state cleared, buffer capacity back to
//   512 bytes, queue emptied, output invalid.
module command_packet_reassembler #(
    parameter int PACKET_SIZE = cpr_pkg::PACKET_SIZE_DEF,
    parameter int QUEUE_DEPTH = cpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Inbound byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_packet_start,
    input  logic        i_response_busy,
    // Configuration write channel (buffer capacity)
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_write_addr,
    output logic [7:0]  o_write_data,
    output logic [31:0] o_chunk_bytes,
    output logic [31:0] o_total_bytes,
    output logic        o_first_chunk,
    output logic        o_streamed,
    output logic        o_last
);
    logic             in_accept;
    logic             push;
    cpr_pkg::t_entry  push_entry;
    cpr_pkg::t_entry  head;
    logic             head_valid;
    logic             q_full;
    logic             pop;
    cpr_pkg::t_result result;

    // Stall inbound transfers only while the queue is full; the back end
    // drains it independently of the front end.
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !o_in_stall;

    // The capacity register takes a transfer at any edge.
    assign o_cfg_ready = 1'b1;

    // Classify each byte and update command state in the cycle it arrives.
    cpr_front #(
        .PACKET_SIZE (PACKET_SIZE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_in_byte       (i_in_byte),
        .i_packet_start  (i_packet_start),
        .i_response_busy (i_response_busy),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    // Buffer classified work so the result side can stall on its own.
    cpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (head_valid),
        .o_full      (q_full)
    );

    // Expand each entry into one or two results behind the output register.
    cpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .i_out_stall  (i_out_stall),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_result     (result)
    );

    assign o_kind        = result.kind;
    assign o_write_addr  = result.write_addr;
    assign o_write_data  = result.write_data;
    assign o_chunk_bytes = result.chunk_bytes;
    assign o_total_bytes = result.total_bytes;
    assign o_first_chunk = result.first_chunk;
    assign o_streamed    = result.streamed;
    assign o_last        = result.last;

endmodule

[hdl/cpr_checker.sv]
// Port-level checker of the command packet reassembler and its bind.
module cpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [15:0] o_write_addr,
    input logic [7:0]  o_write_data,
    input logic [31:0] o_chunk_bytes,
    input logic [31:0] o_total_bytes,
    input logic        o_first_chunk,
    input logic        o_streamed,
    input logic        o_last
);
    // Hold a stalled result.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind))
        else $error("stalled result dropped or changed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == cpr_pkg::KIND_WRITE ||
                         o_kind == cpr_pkg::KIND_DISPATCH ||
                         o_kind == cpr_pkg::KIND_ABORT))
        else $error("illegal result kind");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == cpr_pkg::KIND_WRITE |->
            o_chunk_bytes == 32'd0 && o_total_bytes == 32'd0 &&
            !o_first_chunk && !o_streamed)
        else $error("write result carries dispatch fields");

    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != cpr_pkg::KIND_WRITE |->
            o_last && o_write_addr == 16'd0 && o_write_data == 8'd0)
        else $error("event result not last or carries write fields");

    a_abort_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == cpr_pkg::KIND_ABORT |->
            o_chunk_bytes == 32'd0 && o_total_bytes == 32'd0 &&
            !o_first_chunk && !o_streamed)
        else $error("abort result carries dispatch fields");

endmodule

bind command_packet_reassembler cpr_checker u_cpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_write_addr  (o_write_addr),
    .o_write_data  (o_write_data),
    .o_chunk_bytes (o_chunk_bytes),
    .o_total_bytes (o_total_bytes),
    .o_first_chunk (o_first_chunk),
    .o_streamed    (o_streamed),
    .o_last        (o_last)
);

[test/testbench.sv]
// Self-checking testbench for the command packet reassembler: random packets, scored results.
`timescale 1ns / 1ps

module testbench;

    localparam int PKT         = cpr_pkg::PACKET_SIZE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to let pass after the last result before touching the capacity register.
    localparam int QUIET_CYCLES = 8;

    // One byte of the inbound link together with its sideband flags.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       busy;
    } t_link_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'd0;
    logic        i_packet_start = 1'b0;
    logic        i_response_busy = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_write_addr;
    logic [7:0]  o_write_data;
    logic [31:0] o_chunk_bytes;
    logic [31:0] o_total_bytes;
    logic        o_first_chunk;
    logic        o_streamed;
    logic        o_last;

    command_packet_reassembler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_packet_start (i_packet_start),
        .i_response_busy(i_response_busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_write_addr   (o_write_addr),
        .o_write_data   (o_write_data),
        .o_chunk_bytes  (o_chunk_bytes),
        .o_total_bytes  (o_total_bytes),
        .o_first_chunk  (o_first_chunk),
        .o_streamed     (o_streamed),
        .o_last         (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Reassembly state as the block should hold it
    // ------------------------------------------------------------------
    logic [15:0] buf_capacity  = cpr_pkg::CMD_BUF_RESET;
    logic [5:0]  pos_in_pkt    = '0;
    logic [7:0]  ctl_code      = '0;
    logic [31:0] hdr_len       = '0;
    logic [31:0] cmd_total     = '0;
    logic [31:0] cmd_left      = '0;
    logic [15:0] wr_base       = '0;
    bit          cont_expected = 1'b0;
    bit          stream_cmd    = 1'b0;
    bit          pkt_live      = 1'b0;
    logic [5:0]  chunk_len     = '0;
    bit          chunk_first   = 1'b0;

    cpr_pkg::t_result step_out[$];     // results of the byte being reassembled
    cpr_pkg::t_result results_due[$];  // results the block still owes, oldest first
    t_link_byte       link_bytes[$];   // bytes waiting to go onto the link

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int results_checked = 0;
    int writes_seen     = 0;
    int dispatches_seen = 0;
    int aborts_seen     = 0;
    int capacity_writes = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    function automatic void emit_result(input cpr_pkg::t_kind k, input logic [15:0] addr,
                                        input logic [7:0] data, input logic [31:0] chunk,
                                        input logic [31:0] total, input bit first,
                                        input bit strm);
        cpr_pkg::t_result r;
        r.kind        = k;
        r.write_addr  = addr;
        r.write_data  = data;
        r.chunk_bytes = chunk;
        r.total_bytes = total;
        r.first_chunk = first;
        r.streamed    = strm;
        r.last        = 1'b0;
        step_out.push_back(r);
    endfunction

    // Clear the command and kill the live packet; the streaming mode survives.
    function automatic void abort_command();
        cmd_total     = '0;
        cmd_left      = '0;
        wr_base       = '0;
        cont_expected = 1'b0;
        chunk_len     = '0;
        pkt_live      = 1'b0;
        emit_result(cpr_pkg::KIND_ABORT, '0, '0, '0, '0, 1'b0, 1'b0);
    endfunction

    // Size the chunk of this packet and check it against the buffer capacity.
    function automatic void take_chunk(input logic [31:0] room);
        logic [31:0] c;
        c = (cmd_left < room) ? cmd_left : room;
        if ({1'b0, c} + 33'(wr_base) > 33'(buf_capacity)) begin
            abort_command();
        end else begin
            chunk_first = (cmd_left == cmd_total);
            cmd_left    = cmd_left - c;
            chunk_len   = c[5:0];
            if (!stream_cmd && cmd_left != 0)
                wr_base = wr_base + c[15:0];
        end
    endfunction

    function automatic bit is_start_code(input logic [7:0] code);
        return code == cpr_pkg::CODE_START || code == cpr_pkg::CODE_START_STRM;
    endfunction

    function automatic bit is_cont_code(input logic [7:0] code);
        return code == cpr_pkg::CODE_CONT || code == cpr_pkg::CODE_CONT_STRM;
    endfunction

    // Advance the state by one link byte and queue the results it owes.
    function automatic void reassemble_byte(input logic [7:0] b, input bit pstart,
                                            input bit busy);
        logic [5:0]  idx;
        logic [5:0]  hdr;
        logic [15:0] base;
        bit          from_start;
        cpr_pkg::t_result r;
        if (pstart) begin
            pos_in_pkt = '0;
            ctl_code   = b;
            hdr_len    = '0;
            chunk_len  = '0;
            pkt_live   = !busy;
            if (pkt_live) begin
                if (is_cont_code(b)) begin
                    if (!cont_expected)
                        abort_command();
                    else
                        take_chunk(PKT - cpr_pkg::CONT_HDR_SIZE);
                end else if (!is_start_code(b)) begin
                    abort_command();
                end
            end
        end else if (pkt_live && pos_in_pkt < PKT - 1) begin
            from_start = is_start_code(ctl_code);
            pos_in_pkt = pos_in_pkt + 1'b1;
            idx        = pos_in_pkt;
            hdr        = from_start ? 6'(cpr_pkg::START_HDR_SIZE) :
                                      6'(cpr_pkg::CONT_HDR_SIZE);
            if (from_start && idx < cpr_pkg::START_HDR_SIZE) begin
                // Length arrives little-endian in bytes 1 to 4.
                hdr_len = hdr_len | (32'(b) << (8 * (idx - 1)));
                if (idx == cpr_pkg::START_HDR_SIZE - 1) begin
                    cmd_total     = hdr_len;
                    cmd_left      = hdr_len;
                    wr_base       = '0;
                    cont_expected = 1'b1;
                    stream_cmd    = (ctl_code == cpr_pkg::CODE_START_STRM);
                    take_chunk(PKT - cpr_pkg::START_HDR_SIZE);
                end
            end else if (idx >= hdr && idx - hdr < chunk_len) begin
                // A regular chunk that leaves bytes pending already moved the base.
                base = wr_base;
                if (!stream_cmd && cmd_left != 0)
                    base = wr_base - 16'(chunk_len);
                emit_result(cpr_pkg::KIND_WRITE, base + 16'(idx - hdr), b, '0, '0,
                            1'b0, 1'b0);
            end
            if (pkt_live && idx == PKT - 1) begin
                if (stream_cmd)
                    emit_result(cpr_pkg::KIND_DISPATCH, '0, '0, 32'(chunk_len), cmd_total,
                                chunk_first, 1'b1);
                else if (cmd_left == 0)
                    emit_result(cpr_pkg::KIND_DISPATCH, '0, '0, cmd_total, cmd_total,
                                chunk_first, 1'b0);
                pkt_live = 1'b0;
            end
        end
        while (step_out.size() != 0) begin
            r      = step_out.pop_front();
            r.last = (step_out.size() == 0);
            results_due.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] data, input bit first, input bit busy);
        t_link_byte lb;
        lb.data  = data;
        lb.first = first;
        lb.busy  = busy;
        link_bytes.push_back(lb);
        bytes_queued++;
    endfunction

    // Queue one packet of nbytes bytes; start packets carry len in bytes 1 to 4.
    function automatic void push_packet(input logic [7:0] code, input logic [31:0] len,
                                        input bit busy, input int nbytes);
        logic [7:0] d;
        push_byte(code, 1'b1, busy);
        for (int i = 1; i < nbytes; i++) begin
            if (is_start_code(code) && i < cpr_pkg::START_HDR_SIZE)
                d = len[8 * (i - 1) +: 8];
            else
                d = 8'($urandom_range(255));
            push_byte(d, 1'b0, 1'b0);
        end
    endfunction

    function automatic int pick_pkt_len();
        // Cut a few packets short so the next control byte abandons them.
        return ($urandom_range(99) < 5) ? int'($urandom_range(1, PKT - 1)) : PKT;
    endfunction

    // Queue a well-formed command: start packet and continuations, mostly short.
    function automatic void push_command();
        logic [31:0] len;
        logic [31:0] left;
        logic [7:0]  code;
        int          r;
        r = $urandom_range(99);
        if (r < 10)
            len = $urandom_range(1);
        else if (r < 70)
            len = $urandom_range(2, 200);
        else if (r < 85)
            len = $urandom_range(201, 1000);
        else
            len = $urandom();
        code = $urandom_range(1) ? cpr_pkg::CODE_START_STRM : cpr_pkg::CODE_START;
        push_packet(code, len, $urandom_range(99) < 4, pick_pkt_len());
        left = (len > PKT - cpr_pkg::START_HDR_SIZE) ?
               len - (PKT - cpr_pkg::START_HDR_SIZE) : 0;
        // Cap very long commands; the next start simply replaces them.
        for (int k = 0; k < 4 && left != 0; k++) begin
            code = $urandom_range(1) ? cpr_pkg::CODE_CONT : cpr_pkg::CODE_CONT_STRM;
            push_packet(code, '0, $urandom_range(99) < 4, pick_pkt_len());
            left = (left > PKT - cpr_pkg::CONT_HDR_SIZE) ?
                   left - (PKT - cpr_pkg::CONT_HDR_SIZE) : 0;
        end
        // Now and then trail bytes past the packet end.
        if ($urandom_range(99) < 5) begin
            r = $urandom_range(1, 4);
            for (int j = 0; j < r; j++)
                push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        end
    endfunction

    // Queue something malformed: unknown code, stray continuation or loose bytes.
    function automatic void push_noise();
        logic [7:0] code;
        int         n;
        case ($urandom_range(2))
            0: begin
                code = 8'($urandom_range(255));
                while (is_start_code(code) || is_cont_code(code))
                    code = 8'($urandom_range(255));
                push_packet(code, '0, 1'b0, $urandom_range(1, PKT));
            end
            1: begin
                code = $urandom_range(1) ? cpr_pkg::CODE_CONT : cpr_pkg::CODE_CONT_STRM;
                push_packet(code, '0, 1'b0, PKT);
            end
            default: begin
                n = $urandom_range(1, 5);
                for (int j = 0; j < n; j++)
                    push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            end
        endcase
    endfunction

    function automatic void fill_link(input int n);
        int target;
        target = bytes_queued + n;
        while (bytes_queued < target) begin
            if ($urandom_range(9) == 0)
                push_noise();
            else
                push_command();
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoring
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic score_result(input cpr_pkg::t_result got, input cpr_pkg::t_result want);
        if (got.kind != want.kind)
            flag_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.write_addr != want.write_addr)
            flag_mismatch("write_addr", 32'(got.write_addr), 32'(want.write_addr));
        if (got.write_data != want.write_data)
            flag_mismatch("write_data", 32'(got.write_data), 32'(want.write_data));
        if (got.chunk_bytes != want.chunk_bytes)
            flag_mismatch("chunk_bytes", got.chunk_bytes, want.chunk_bytes);
        if (got.total_bytes != want.total_bytes)
            flag_mismatch("total_bytes", got.total_bytes, want.total_bytes);
        if (got.first_chunk != want.first_chunk)
            flag_mismatch("first_chunk", 32'(got.first_chunk), 32'(want.first_chunk));
        if (got.streamed != want.streamed)
            flag_mismatch("streamed", 32'(got.streamed), 32'(want.streamed));
        if (got.last != want.last)
            flag_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // ------------------------------------------------------------------
    // Link driver: predict each accepted transfer, then offer the next byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_link
        t_link_byte nxt;
        if (!i_rst_n) begin
            i_in_valid      <= 1'b0;
            i_in_byte       <= 8'd0;
            i_packet_start  <= 1'b0;
            i_response_busy <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                reassemble_byte(i_in_byte, i_packet_start, i_response_busy);
                bytes_accepted++;
            end
            // Hold a stalled byte; otherwise offer the next one or idle.
            if (!i_in_valid || !o_in_stall) begin
                if (link_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = link_bytes.pop_front();
                    i_in_valid      <= 1'b1;
                    i_in_byte       <= nxt.data;
                    i_packet_start  <= nxt.first;
                    i_response_busy <= nxt.busy;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, score each accepted transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        cpr_pkg::t_result got;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (o_out_valid && !i_out_stall) begin
                got.kind        = cpr_pkg::t_kind'(o_kind);
                got.write_addr  = o_write_addr;
                got.write_data  = o_write_data;
                got.chunk_bytes = o_chunk_bytes;
                got.total_bytes = o_total_bytes;
                got.first_chunk = o_first_chunk;
                got.streamed    = o_streamed;
                got.last        = o_last;
                case (got.kind)
                    cpr_pkg::KIND_WRITE:    writes_seen++;
                    cpr_pkg::KIND_DISPATCH: dispatches_seen++;
                    default:                aborts_seen++;
                endcase
                if (results_due.size() == 0)
                    flag_mismatch("unexpected result of kind", 32'(o_kind), 32'(0));
                else
                    score_result(got, results_due.pop_front());
                results_checked++;
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, results_due.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    // Wait until the link is empty, every result has arrived and the block is quiet.
    task automatic settle();
        while (link_bytes.size() != 0 || i_in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        buf_capacity = value;
        capacity_writes++;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corner cases on short sequences at the reset capacity.
        write_capacity(cpr_pkg::CMD_BUF_RESET);
        push_byte(8'h5A, 1'b0, 1'b0);                     // loose byte before any packet
        push_byte(cpr_pkg::CODE_CONT_STRM, 1'b1, 1'b0);   // continuation nobody asked for
        push_byte(8'h00, 1'b1, 1'b0);                     // unknown codes
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);                     // byte after an abort
        push_byte(cpr_pkg::CODE_START, 1'b1, 1'b1);       // response busy: packet ignored
        push_byte(8'hA5, 1'b0, 1'b0);
        push_byte(cpr_pkg::CODE_START_STRM, 1'b1, 1'b0);  // maximum length, then cut short
        repeat (4) push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(cpr_pkg::CODE_START, 1'b1, 1'b0);       // zero length command
        repeat (4) push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(cpr_pkg::CODE_CONT, 1'b1, 1'b0);        // empty continuation
        push_byte(8'h80, 1'b0, 1'b0);
        settle();

        // Full flow, no idling, largest buffer.
        sender_idle_pct = 0;
        stall_pct       = 0;
        write_capacity(16'hFFFF);
        fill_link(500);
        settle();

        // Sparse sender, buffer that overruns on the second chunk; pause midway
        // until the block has delivered everything.
        sender_idle_pct = 54;
        write_capacity(16'd100);
        fill_link(250);
        settle();
        fill_link(250);
        settle();

        // Heavy back-pressure, one-byte buffer.
        sender_idle_pct = 0;
        stall_pct       = 54;
        write_capacity(16'd1);
        fill_link(500);
        settle();

        // Both sides idling, random buffer size.
        sender_idle_pct = 20;
        stall_pct       = 20;
        write_capacity(16'($urandom_range(60, 600)));
        fill_link(500);
        settle();

        if (results_due.size() != 0)
            flag_mismatch("results never delivered", 32'(results_due.size()), 32'(0));

        $display("Sent %0d link bytes over %0d buffer capacities in %0d cycles.",
                 bytes_accepted, capacity_writes, cycle_count);
        $display("Scored %0d results: %0d writes, %0d dispatches, %0d aborts; %0d mismatches.",
                 results_checked, writes_seen, dispatches_seen, aborts_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[command_packet_reassembler.f]
hdl/cpr_pkg.sv
hdl/cpr_front.sv
hdl/cpr_queue.sv
hdl/cpr_back.sv
hdl/command_packet_reassembler.sv
hdl/cpr_checker.sv
test/testbench.sv
